// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and muted in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/cpma_pkg.sv
// ----------------------------------------------------------------------------
// cpma_pkg
// Types and fixed constants for the centered pose moving-average smoother.
// ----------------------------------------------------------------------------
package cpma_pkg;

  localparam int POS_W  = 32;
  localparam int HEAD_W = 16;
  localparam int WS_W   = 5;

  // Pi and two pi in Q3.13, held one bit wider than a heading.
  localparam logic signed [HEAD_W:0] PI_Q13     = 17'sd25736;
  localparam logic signed [HEAD_W:0] TWO_PI_Q13 = 17'sd51472;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_PASS     = 9'b000000010,
    S_DROP_RD  = 9'b000000100,
    S_DROP_SUB = 9'b000001000,
    S_PUSH     = 9'b000010000,
    S_FLUSH    = 9'b000100000,
    S_DIV_GO   = 9'b001000000,
    S_DIV_RUN  = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    FLD_X = 2'd0,
    FLD_Y = 2'd1,
    FLD_H = 2'd2
  } fld_t;

  // Divider start request; narrow selects the short heading dividend.
  typedef struct packed {
    logic go;
    logic narrow;
  } div_ctl_t;

  // Wrap a mean heading into [-pi, pi).
  function automatic logic [HEAD_W-1:0] wrap_heading(input logic [HEAD_W-1:0] mh);
    logic signed [HEAD_W:0] m;
    m = {mh[HEAD_W-1], mh};
    if (m >= PI_Q13) begin
      m = m - TWO_PI_Q13;
    end else if (m < -PI_Q13) begin
      m = m + TWO_PI_Q13;
    end
    return m[HEAD_W-1:0];
  endfunction

endpackage

// File: rtl/cpma_win.sv
// ----------------------------------------------------------------------------
// cpma_win
// Circular pose window memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpma_win
  import cpma_pkg::*;
#(
  parameter int DEPTH = 31,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [POS_W-1:0]  wr_x,
  input  logic [POS_W-1:0]  wr_y,
  input  logic [HEAD_W-1:0] wr_heading,
  input  logic [AW-1:0]     rd_addr,
  output logic [POS_W-1:0]  rd_x,
  output logic [POS_W-1:0]  rd_y,
  output logic [HEAD_W-1:0] rd_heading
);

  logic [POS_W-1:0]  mem_x [DEPTH];
  logic [POS_W-1:0]  mem_y [DEPTH];
  logic [HEAD_W-1:0] mem_h [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
      mem_h[wr_addr] <= wr_heading;
    end
  end

  always_ff @(posedge clk) begin
    rd_x       <= mem_x[rd_addr];
    rd_y       <= mem_y[rd_addr];
    rd_heading <= mem_h[rd_addr];
  end

endmodule

// File: rtl/cpma_div.sv
// ----------------------------------------------------------------------------
// cpma_div
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpma_div
  import cpma_pkg::*;
#(
  parameter int SUM_W    = 37,
  parameter int NARROW_W = 21,
  parameter int CNT_W    = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int IT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic [IT_W-1:0]  iter;
  logic             neg;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;

  logic [CNT_W:0]   trial;
  logic             fits;
  logic [CNT_W-1:0] rem_next;
  logic [SUM_W-1:0] quo_next;
  logic [SUM_W-1:0] mag_abs;
  logic [SUM_W-1:0] mag_load;

  always_comb begin
    trial    = {rem, mag[SUM_W-1]};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
    quo_next = {quo[SUM_W-2:0], fits};
    mag_abs  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    // The heading sum is small; align it to the top so fewer steps are needed.
    mag_load = ctl.narrow ? (mag_abs << (SUM_W - NARROW_W)) : mag_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        busy <= 1'b1;
        iter <= ctl.narrow ? IT_W'(NARROW_W) : IT_W'(SUM_W);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == IT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      neg <= dividend[SUM_W-1];
      mag <= mag_load;
      quo <= '0;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      mag <= {mag[SUM_W-2:0], 1'b0};
      quo <= quo_next;
      rem <= rem_next;
      if (iter == IT_W'(1)) begin
        quotient <= neg ? (~quo_next + 1'b1) : quo_next;
      end
    end
  end

  `ASSERT_IMPLIES(a_go_when_idle, ctl.go, !busy)
  `ASSERT_IMPLIES(a_rem_below_divisor, busy, rem < dvs)
  `ASSERT_NEXT(a_done_ends_busy, done, !busy)

endmodule

// File: rtl/centered_pose_moving_average_top.sv
// ----------------------------------------------------------------------------
// centered_pose_moving_average_top
// Centered moving-average smoother for a stream of 2D poses.
// ----------------------------------------------------------------------------
// Input words (pose_x, pose_y, pose_heading, is_final) arrive on the
// pose_valid/pose_ready channel; smoothed words leave on mean_valid/mean_ready.
// Each pose is replaced by the mean over the poses from h before to h after it,
// h = win_size/2, with the window clipped at both ends of the trajectory.
// Results lag the input by h words, and the word with is_final set flushes the
// pending results; the last of them carries end_of_run.
// Throughput: the block takes one word at a time. A mean costs three passes
// of one shared bit-serial divider (one step per dividend bit: SUM_W = 37 for
// x and y, HSUM_W = 21 for heading), each started in S_DIV_GO and finished in
// S_DIV_RUN, after which S_EMIT loads the output register. A push goes through
// S_PUSH, preceded by S_DROP_RD and S_DROP_SUB when the oldest pose is dropped
// first. Each further flush result passes S_FLUSH, plus S_DROP_RD and
// S_DROP_SUB for each dropped pose. A pass-through word (h of zero) goes from
// S_IDLE through S_PASS, which loads it into the output register.
// The output register lets a finished word wait while the receiver stalls;
// the sequencer only stops when it needs that register again.
// Reset sets win_size to 1 (pass through) and empties the window; a write
// to win_size also abandons a partial trajectory. No clearing pass exists.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module centered_pose_moving_average_top
  import cpma_pkg::*;
#(
  parameter int MAX_HALF_WINDOW = 15
) (
  input  logic              clk,
  input  logic              rst,

  input  logic              cfg_wr_en,
  input  logic [WS_W-1:0]   cfg_wr_data,

  input  logic              pose_valid,
  output logic              pose_ready,
  input  logic [POS_W-1:0]  pose_x,
  input  logic [POS_W-1:0]  pose_y,
  input  logic [HEAD_W-1:0] pose_heading,
  input  logic              is_final,

  output logic              mean_valid,
  input  logic              mean_ready,
  output logic [POS_W-1:0]  mean_x,
  output logic [POS_W-1:0]  mean_y,
  output logic [HEAD_W-1:0] mean_heading,
  output logic              end_of_run
);

  localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = AW + 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = POS_W + $clog2(DEPTH);
  localparam int HSUM_W = HEAD_W + $clog2(DEPTH);

  // Control state.
  state_t                   state, state_next;
  logic [WS_W-1:0]          win_size;
  logic [CNT_W-1:0]         held;
  logic [AW-1:0]            head;
  logic                     flushing;
  logic [CNT_W-1:0]         k;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic signed [HSUM_W-1:0] sum_h;

  // Captured input word and per-mean payload.
  logic [POS_W-1:0]  in_x;
  logic [POS_W-1:0]  in_y;
  logic [HEAD_W-1:0] in_h;
  logic              in_fin;
  logic              last;
  fld_t              fld;
  logic [POS_W-1:0]  q_x;
  logic [POS_W-1:0]  q_y;
  logic [HEAD_W-1:0] q_h;

  // Derived window geometry.
  logic [CNT_W-1:0] h;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] held_inc;
  logic [CNT_W-1:0] kh;
  logic [CNT_W-1:0] rem_push;
  logic [CNT_W-1:0] rem_emit;
  logic [PW-1:0]    ptr_sum;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    head_inc;

  logic              slot_free;
  logic              out_load;
  logic              win_wr_en;
  logic [POS_W-1:0]  rd_x;
  logic [POS_W-1:0]  rd_y;
  logic [HEAD_W-1:0] rd_h;

  div_ctl_t         div_ctl;
  logic [SUM_W-1:0] div_dividend;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;

  always_comb begin
    if (int'(win_size[WS_W-1:1]) > MAX_HALF_WINDOW) begin
      h = CNT_W'(MAX_HALF_WINDOW);
    end else begin
      h = CNT_W'(win_size[WS_W-1:1]);
    end
    cap      = {h[CNT_W-2:0], 1'b1};
    held_inc = held + 1'b1;
    kh       = k + h;
    rem_push = (held_inc < h) ? held_inc : h;
    rem_emit = (held < h) ? held : h;
    // The newest pose goes just past the held ones, modulo the depth.
    ptr_sum  = PW'(head) + PW'(held);
    tail     = (ptr_sum >= PW'(DEPTH)) ? AW'(ptr_sum - PW'(DEPTH)) : ptr_sum[AW-1:0];
    head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  end

  assign slot_free  = !mean_valid || mean_ready;
  assign pose_ready = (state == S_IDLE);
  assign win_wr_en  = (state == S_PUSH);

  // Sequencer.
  always_comb begin
    state_next     = state;
    out_load       = 1'b0;
    div_ctl.go     = 1'b0;
    div_ctl.narrow = 1'b0;
    case (state)
      S_IDLE: begin
        if (pose_valid) begin
          if (h == '0) begin
            state_next = S_PASS;
          end else if (held == cap) begin
            state_next = S_DROP_RD;
          end else begin
            state_next = S_PUSH;
          end
        end
      end
      S_PASS: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DROP_RD: begin
        state_next = S_DROP_SUB;
      end
      S_DROP_SUB: begin
        state_next = flushing ? S_FLUSH : S_PUSH;
      end
      S_PUSH: begin
        if (held_inc > h) begin
          state_next = S_DIV_GO;
        end else if (in_fin) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (k == '0) begin
          state_next = S_IDLE;
        end else if (held > kh) begin
          state_next = S_DROP_RD;
        end else begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_ctl.go     = 1'b1;
        div_ctl.narrow = (fld == FLD_H);
        state_next     = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (div_done) begin
          state_next = (fld == FLD_H) ? S_EMIT : S_DIV_GO;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = (flushing || in_fin) ? S_FLUSH : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    case (fld)
      FLD_X:   div_dividend = sum_x;
      FLD_Y:   div_dividend = sum_y;
      FLD_H:   div_dividend = {{(SUM_W - HSUM_W){sum_h[HSUM_W-1]}}, sum_h};
      default: div_dividend = sum_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      win_size    <= WS_W'(1);
      held        <= '0;
      head        <= '0;
      flushing    <= 1'b0;
      k           <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      sum_h       <= '0;
      mean_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        mean_valid <= 1'b1;
      end else if (mean_ready) begin
        mean_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        // A new window size starts a fresh trajectory.
        win_size <= cfg_wr_data;
        held     <= '0;
        head     <= '0;
        flushing <= 1'b0;
        k        <= '0;
        sum_x    <= '0;
        sum_y    <= '0;
        sum_h    <= '0;
      end else begin
        case (state)
          S_IDLE: begin
            if (pose_valid) begin
              in_x   <= pose_x;
              in_y   <= pose_y;
              in_h   <= pose_heading;
              in_fin <= is_final;
            end
          end
          S_DROP_SUB: begin
            sum_x <= sum_x - {{(SUM_W - POS_W){rd_x[POS_W-1]}}, rd_x};
            sum_y <= sum_y - {{(SUM_W - POS_W){rd_y[POS_W-1]}}, rd_y};
            sum_h <= sum_h - {{(HSUM_W - HEAD_W){rd_h[HEAD_W-1]}}, rd_h};
            head  <= head_inc;
            held  <= held - 1'b1;
          end
          S_PUSH: begin
            sum_x <= sum_x + {{(SUM_W - POS_W){in_x[POS_W-1]}}, in_x};
            sum_y <= sum_y + {{(SUM_W - POS_W){in_y[POS_W-1]}}, in_y};
            sum_h <= sum_h + {{(HSUM_W - HEAD_W){in_h[HEAD_W-1]}}, in_h};
            held  <= held_inc;
            fld   <= FLD_X;
            last  <= 1'b0;
            // Too few poses for a centered mean: a final word goes straight to
            // flushing.
            if (!(held_inc > h) && in_fin) begin
              flushing <= 1'b1;
              k        <= rem_push;
            end
          end
          S_FLUSH: begin
            if (k == '0) begin
              held     <= '0;
              head     <= '0;
              flushing <= 1'b0;
              sum_x    <= '0;
              sum_y    <= '0;
              sum_h    <= '0;
            end else if (!(held > kh)) begin
              last <= (k == CNT_W'(1));
              fld  <= FLD_X;
            end
          end
          S_DIV_RUN: begin
            if (div_done) begin
              case (fld)
                FLD_X: begin
                  q_x <= div_quotient[POS_W-1:0];
                  fld <= FLD_Y;
                end
                FLD_Y: begin
                  q_y <= div_quotient[POS_W-1:0];
                  fld <= FLD_H;
                end
                FLD_H: begin
                  q_h <= wrap_heading(div_quotient[HEAD_W-1:0]);
                end
                default: begin
                  fld <= FLD_X;
                end
              endcase
            end
          end
          S_EMIT: begin
            if (slot_free) begin
              if (flushing) begin
                k <= k - 1'b1;
              end else if (in_fin) begin
                flushing <= 1'b1;
                k        <= rem_emit;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_PASS) begin
        mean_x       <= in_x;
        mean_y       <= in_y;
        mean_heading <= in_h;
        end_of_run   <= in_fin;
      end else begin
        mean_x       <= q_x;
        mean_y       <= q_y;
        mean_heading <= q_h;
        end_of_run   <= last;
      end
    end
  end

  cpma_win #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_win (
    .clk        (clk),
    .wr_en      (win_wr_en),
    .wr_addr    (tail),
    .wr_x       (in_x),
    .wr_y       (in_y),
    .wr_heading (in_h),
    .rd_addr    (head),
    .rd_x       (rd_x),
    .rd_y       (rd_y),
    .rd_heading (rd_h)
  );

  cpma_div #(
    .SUM_W    (SUM_W),
    .NARROW_W (HSUM_W),
    .CNT_W    (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (held),
    .done     (div_done),
    .quotient (div_quotient)
  );

  `ASSERT_ALWAYS(a_held_within_cap, (h == '0) || (held <= cap))
  `ASSERT_ALWAYS(a_flush_count_bound, k <= h)
  `ASSERT_IMPLIES(a_no_divide_by_zero, state == S_DIV_GO, held != '0)
  `ASSERT_NEXT(a_push_counts_one, (state == S_PUSH) && !cfg_wr_en, held == $past(held_inc))

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the centered pose moving-average smoother.
// ----------------------------------------------------------------------------
// A table of directed poses and window settings runs first, then randomized
// trajectories under changing window sizes. Every accepted pose is fed to an
// in-bench model of the smoother, and each smoothed word that leaves the block
// is checked field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_top
  import cpma_pkg::*;
();

  localparam int unsigned HALF_CAP        = 15;
  localparam int unsigned WINDOW_DEPTH    = 2 * HALF_CAP + 1;
  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned TOTAL_POSES     = 410;
  // A pose that yields no mean may still be in flight when the last expected
  // word has arrived.
  localparam int unsigned SETTLE_CYCLES   = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;
  localparam int unsigned STALL_LIMIT     = 20000;
  localparam int unsigned SHOWN_ERRORS    = 10;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [HEAD_W-1:0] hd;
    logic              fin;
  } pose_t;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [HEAD_W-1:0] hd;
    logic              eor;
  } mean_t;

  // A directed row either rewrites the window size or offers one pose. For a
  // pose whose result is obvious (pass through) the result is typed in.
  typedef enum logic [1:0] {
    ROW_CFG        = 2'd0,
    ROW_POSE       = 2'd1,
    ROW_POSE_KNOWN = 2'd2
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [4:0]  ws;
    pose_t       pose;
    mean_t       known;
  } stim_row_t;

  localparam int unsigned N_ROWS = 22;

  stim_row_t directed_rows [N_ROWS] = '{
    // Pass through after reset: extremes come back untouched, heading unwrapped.
    '{ROW_POSE_KNOWN, 5'd0, '{32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 1'b0},
                            '{32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 1'b0}},
    '{ROW_POSE_KNOWN, 5'd0, '{32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1'b1},
                            '{32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1'b1}},
    '{ROW_POSE_KNOWN, 5'd0, '{32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 1'b0},
                            '{32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 1'b0}},
    // A window size of zero also passes poses through, even a heading of pi.
    '{ROW_CFG,        5'd0, '0, '0},
    '{ROW_POSE_KNOWN, 5'd0, '{32'h0001_8000, 32'hFFFE_8000, 16'h6488, 1'b1},
                            '{32'h0001_8000, 32'hFFFE_8000, 16'h6488, 1'b1}},
    // Half width one: full-scale sums, a mean heading of exactly pi that must
    // wrap down, a mean of -32768 that must wrap up, and a one-pose trajectory.
    '{ROW_CFG,        5'd3, '0, '0},
    '{ROW_POSE,       5'd0, '{32'h7FFF_FFFF, 32'h8000_0000, 16'h6488, 1'b0}, '0},
    '{ROW_POSE,       5'd0, '{32'h7FFF_FFFF, 32'h8000_0000, 16'h6488, 1'b0}, '0},
    '{ROW_POSE,       5'd0, '{32'h7FFF_FFFF, 32'h8000_0000, 16'h6488, 1'b1}, '0},
    '{ROW_POSE,       5'd0, '{32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1'b0}, '0},
    '{ROW_POSE,       5'd0, '{32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1'b1}, '0},
    '{ROW_POSE,       5'd0, '{32'h0000_0003, 32'hFFFF_FFFD, 16'h9B78, 1'b1}, '0},
    // Widest window with a trajectory far shorter than its half width.
    '{ROW_CFG,        5'd31, '0, '0},
    '{ROW_POSE,       5'd0, '{32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 1'b0}, '0},
    '{ROW_POSE,       5'd0, '{32'h8000_0000, 32'h7FFF_FFFF, 16'h8001, 1'b0}, '0},
    '{ROW_POSE,       5'd0, '{32'h0000_0001, 32'hFFFF_FFFF, 16'h0001, 1'b1}, '0},
    // A trajectory cut short by a register write leaves nothing behind.
    '{ROW_CFG,        5'd5, '0, '0},
    '{ROW_POSE,       5'd0, '{32'h1234_5678, 32'h8765_4321, 16'h1000, 1'b0}, '0},
    '{ROW_POSE,       5'd0, '{32'h0BAD_F00D, 32'hF00D_0BAD, 16'hF000, 1'b0}, '0},
    '{ROW_CFG,        5'd2, '0, '0},
    '{ROW_POSE,       5'd0, '{32'h0000_0007, 32'hFFFF_FFF9, 16'h0003, 1'b0}, '0},
    '{ROW_POSE,       5'd0, '{32'h0000_0008, 32'hFFFF_FFF8, 16'h0004, 1'b1}, '0}
  };

  // DUT ports. Every input holds a known value from time zero.
  logic              clk;
  logic              rst          = 1'b1;
  logic              cfg_wr_en    = 1'b0;
  logic [WS_W-1:0]   cfg_wr_data  = '0;
  logic              pose_valid   = 1'b0;
  logic              pose_ready;
  logic [POS_W-1:0]  pose_x       = '0;
  logic [POS_W-1:0]  pose_y       = '0;
  logic [HEAD_W-1:0] pose_heading = '0;
  logic              is_final     = 1'b0;
  logic              mean_valid;
  logic              mean_ready   = 1'b0;
  logic [POS_W-1:0]  mean_x;
  logic [POS_W-1:0]  mean_y;
  logic [HEAD_W-1:0] mean_heading;
  logic              end_of_run;

  // Bench model of the smoother: the held poses, oldest first, their sums and
  // the window size the block was last given.
  int unsigned        window_len = 1;
  logic signed [31:0] held_x  [WINDOW_DEPTH];
  logic signed [31:0] held_y  [WINDOW_DEPTH];
  logic signed [15:0] held_hd [WINDOW_DEPTH];
  longint             sum_x, sum_y, sum_hd;
  int unsigned        held_count;

  mean_t       fresh_means [$];     // words caused by the pose just accepted
  mean_t       expected_means [$];  // words predicted but not yet seen
  mean_t       oldest_mean;

  int unsigned burst_left;
  int unsigned poses_sent;
  int unsigned means_checked;
  int unsigned mismatch_count;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  bit          hold_off_armed;
  bit          hold_off_used;
  bit          hold_off_done;

  centered_pose_moving_average_top #(
    .MAX_HALF_WINDOW(HALF_CAP)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .pose_valid   (pose_valid),
    .pose_ready   (pose_ready),
    .pose_x       (pose_x),
    .pose_y       (pose_y),
    .pose_heading (pose_heading),
    .is_final     (is_final),
    .mean_valid   (mean_valid),
    .mean_ready   (mean_ready),
    .mean_x       (mean_x),
    .mean_y       (mean_y),
    .mean_heading (mean_heading),
    .end_of_run   (end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Smoother model
  // ------------------------------------------------------------------------

  function automatic void clear_window();
    held_count = 0;
    sum_x      = 0;
    sum_y      = 0;
    sum_hd     = 0;
  endfunction

  function automatic void drop_oldest_pose();
    int unsigned i;
    sum_x  -= held_x[0];
    sum_y  -= held_y[0];
    sum_hd -= held_hd[0];
    for (i = 1; i < held_count; i++) begin
      held_x[i-1]  = held_x[i];
      held_y[i-1]  = held_y[i];
      held_hd[i-1] = held_hd[i];
    end
    held_count--;
  endfunction

  // Mean over every held pose, truncated toward zero, heading wrapped once
  // into [-pi, pi).
  function automatic void emit_mean(input logic eor);
    longint n;
    longint mh;
    mean_t  m;
    n  = longint'(held_count);
    mh = sum_hd / n;
    if (mh >= longint'(PI_Q13)) begin
      mh -= longint'(TWO_PI_Q13);
    end else if (mh < -longint'(PI_Q13)) begin
      mh += longint'(TWO_PI_Q13);
    end
    m.x   = 32'(sum_x / n);
    m.y   = 32'(sum_y / n);
    m.hd  = 16'(mh);
    m.eor = eor;
    fresh_means.insert(fresh_means.size(), m);
  endfunction

  // Advance the model by one accepted pose and leave its words in fresh_means.
  function automatic void smooth_pose(input pose_t p);
    int unsigned half;
    int unsigned left;
    int unsigned k;
    mean_t       m;
    fresh_means.delete();
    half = window_len / 2;
    if (half > HALF_CAP) begin
      half = HALF_CAP;
    end
    if (half == 0) begin
      m.x   = p.x;
      m.y   = p.y;
      m.hd  = p.hd;
      m.eor = p.fin;
      fresh_means.insert(fresh_means.size(), m);
      return;
    end
    while (held_count >= 2 * half + 1) begin
      drop_oldest_pose();
    end
    held_x[held_count]  = p.x;
    held_y[held_count]  = p.y;
    held_hd[held_count] = p.hd;
    sum_x  += longint'($signed(p.x));
    sum_y  += longint'($signed(p.y));
    sum_hd += longint'($signed(p.hd));
    held_count++;
    if (held_count > half) begin
      emit_mean(1'b0);
    end
    if (p.fin) begin
      // Flush: each remaining word sees the window shrink from the old end
      // until only the poses it still centers on are held.
      left = (held_count < half) ? held_count : half;
      for (k = left; k > 0; k--) begin
        while (held_count > k + half) begin
          drop_oldest_pose();
        end
        emit_mean(k == 1);
      end
      clear_window();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic pose_t random_pose(input logic fin);
    pose_t p;
    p.x   = random_coord();
    p.y   = random_coord();
    p.fin = fin;
    // Headings cluster near both ends of the circle so that the means land on
    // either side of the wrap points.
    case ($urandom_range(0, 4))
      0: p.hd = 16'(int'(PI_Q13) - 700 + int'($urandom_range(0, 1400)));
      1: p.hd = 16'(-int'(PI_Q13) - 700 + int'($urandom_range(0, 1400)));
      2: p.hd = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: p.hd = 16'($urandom);
    endcase
    return p;
  endfunction

  // Offer one pose word and hold it until the block takes it. The sender
  // works in bursts; between bursts valid drops for a random gap, and about a
  // third of the bursts follow the previous one without any gap.
  task automatic offer_pose(input pose_t p, input logic use_known, input mean_t known);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        pose_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pose_valid   <= 1'b1;
    pose_x       <= p.x;
    pose_y       <= p.y;
    pose_heading <= p.hd;
    is_final     <= p.fin;
    do @(posedge clk); while (!pose_ready);
    smooth_pose(p);
    if (use_known) begin
      expected_means.insert(expected_means.size(), known);
    end else begin
      foreach (fresh_means[i]) expected_means.insert(expected_means.size(), fresh_means[i]);
    end
    poses_sent++;
  endtask

  // Window size changes only with the block idle: every predicted word back,
  // then a settling pause for any pose that produced no word yet.
  task automatic set_window(input logic [4:0] ws);
    pose_valid <= 1'b0;
    burst_left = 0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ws;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_len = ws;
    clear_window();
    settings_used++;
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    stim_row_t   row;
    logic [4:0]  ws;
    int unsigned half;
    int unsigned len;
    int unsigned n_traj;
    int unsigned t;
    int unsigned j;

    clear_window();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: pass through, wrap points, short and abandoned runs.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        set_window(row.ws);
      end else begin
        offer_pose(row.pose, row.kind == ROW_POSE_KNOWN, row.known);
      end
    end

    // Random phases. Each picks a window size, sends a few complete
    // trajectories with random content, and sometimes leaves a broken one
    // for the next register write to abandon. The pose budget cuts the last
    // trajectory short if needed.
    while (poses_sent < TOTAL_POSES) begin
      case ($urandom_range(0, 7))
        0: ws = 5'd1;
        1: ws = 5'd0;
        2: ws = 5'd31;
        3: ws = 5'($urandom_range(28, 30));
        default: ws = 5'($urandom_range(2, 9));
      endcase
      set_window(ws);
      half = ws / 2;
      n_traj = $urandom_range(1, 3);
      for (t = 0; t < n_traj; t++) begin
        case ($urandom_range(0, 4))
          0: len = $urandom_range(1, half + 1);
          1: len = $urandom_range(30, 48);
          default: len = $urandom_range(half + 1, 2 * half + 6);
        endcase
        // Once, well into the run, the receiver holds off for a long stretch
        // while this trajectory keeps coming, so the block backs up.
        if (!hold_off_used && poses_sent >= 150 && half != 0) begin
          hold_off_used  = 1'b1;
          hold_off_armed = 1'b1;
          if (len < 40) begin
            len = 40;
          end
        end
        for (j = 1; j <= len && poses_sent < TOTAL_POSES; j++) begin
          offer_pose(random_pose(j == len), 1'b0, '0);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(1, 2 * half + 3);
        for (j = 0; j < len && poses_sent < TOTAL_POSES; j++) begin
          offer_pose(random_pose(1'b0), 1'b0, '0);
        end
      end
    end

    pose_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d poses under %0d window settings; %0d smoothed words checked",
             poses_sent, settings_used, means_checked);
    $display("long receiver hold-off %s; %0d mismatching words",
             hold_off_done ? "exercised" : "not reached", mismatch_count);
    if (mismatch_count == 0 && expected_means.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // Receiver: ready follows a changing pattern (always ready, coin flips,
  // one cycle in four, or mostly ready), and honors the long hold-off once.
  // ------------------------------------------------------------------------
  initial begin
    int unsigned pattern;
    int unsigned span;
    int unsigned cyc;
    bit          leave;

    while (rst) @(posedge clk);
    forever begin
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        mean_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        pattern = $urandom_range(0, 3);
        span    = $urandom_range(16, 160);
        leave   = 1'b0;
        for (cyc = 0; cyc < span && !leave; cyc++) begin
          case (pattern)
            0: mean_ready <= 1'b1;
            1: mean_ready <= 1'($urandom_range(0, 1));
            2: mean_ready <= (cyc % 4 == 0);
            default: mean_ready <= (cyc % 7 != 0);
          endcase
          @(posedge clk);
          leave = hold_off_armed;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Checker: every accepted smoothed word must match the oldest prediction.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && mean_valid && mean_ready) begin
      means_checked++;
      if (expected_means.size() == 0) begin
        if (mismatch_count < SHOWN_ERRORS) begin
          $display("unexpected smoothed word: x=%h y=%h heading=%h end_of_run=%b",
                   mean_x, mean_y, mean_heading, end_of_run);
        end
        mismatch_count++;
      end else begin
        oldest_mean = expected_means.pop_front();
        if (mean_x !== oldest_mean.x || mean_y !== oldest_mean.y ||
            mean_heading !== oldest_mean.hd || end_of_run !== oldest_mean.eor) begin
          if (mismatch_count < SHOWN_ERRORS) begin
            $display("word %0d mismatch: expected x=%h y=%h heading=%h end_of_run=%b",
                     means_checked, oldest_mean.x, oldest_mean.y, oldest_mean.hd,
                     oldest_mean.eor);
            $display("word %0d mismatch: actual   x=%h y=%h heading=%h end_of_run=%b",
                     means_checked, mean_x, mean_y, mean_heading, end_of_run);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no word moving on either channel
  // means the block has hung.
  always @(posedge clk) begin
    if (rst || (pose_valid && pose_ready) || (mean_valid && mean_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
